FILE: rtl/asp_pkg.sv
package asp_pkg;

    localparam int SEQ_MAX  = 31;
    localparam int COL_BITS = 12;
    localparam int CNT_W    = $clog2(SEQ_MAX + 1);
    localparam int BYTE_W   = 8;
    localparam int COL_W    = 12;
    localparam int NUM_W    = 16;
    localparam int COLOR_W  = 32;
    localparam int TERM_W   = 4;

    localparam logic [NUM_W-1:0]   NUM_SAT = 16'hffff;
    localparam logic [COLOR_W-1:0] WHITE   = 32'hffffffff;
    localparam logic [COLOR_W-1:0] BLACK   = 32'h00000000;
    localparam logic [COL_W-1:0]   COL_MASK = COL_W'((64'd1 << COL_BITS) - 64'd1);

    localparam logic [BYTE_W-1:0] CHAR_SEMI = ";";
    localparam logic [BYTE_W-1:0] CHAR_0    = "0";
    localparam logic [BYTE_W-1:0] CHAR_9    = "9";

    localparam logic [TERM_W-1:0] TERM_M = 4'd0;
    localparam logic [TERM_W-1:0] TERM_J = 4'd1;
    localparam logic [TERM_W-1:0] TERM_K = 4'd2;
    localparam logic [TERM_W-1:0] TERM_A = 4'd3;
    localparam logic [TERM_W-1:0] TERM_B = 4'd4;
    localparam logic [TERM_W-1:0] TERM_C = 4'd5;
    localparam logic [TERM_W-1:0] TERM_D = 4'd6;
    localparam logic [TERM_W-1:0] TERM_E = 4'd7;
    localparam logic [TERM_W-1:0] TERM_F = 4'd8;
    localparam logic [TERM_W-1:0] TERM_G = 4'd9;
    localparam logic [TERM_W-1:0] TERM_H = 4'd10;
    localparam logic [TERM_W-1:0] TERM_N = 4'd11;
    localparam logic [TERM_W-1:0] TERM_S = 4'd12;
    localparam logic [TERM_W-1:0] TERM_U = 4'd13;

    typedef struct packed {
        logic [BYTE_W-1:0] seq_byte;
        logic [COL_W-1:0]  cursor_col;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               move_valid;
        logic [COL_W-1:0]   new_cursor_col;
        logic [TERM_W-1:0]  term_code;
    } res_item_t;

    typedef struct packed {
        logic              hit;
        logic [TERM_W-1:0] code;
    } term_hit_t;

    function automatic term_hit_t term_lookup(input logic [BYTE_W-1:0] b);
        term_hit_t r;
        r.hit  = 1'b1;
        r.code = TERM_M;
        unique case (b)
            "m":     r.code = TERM_M;
            "J":     r.code = TERM_J;
            "K":     r.code = TERM_K;
            "A":     r.code = TERM_A;
            "B":     r.code = TERM_B;
            "C":     r.code = TERM_C;
            "D":     r.code = TERM_D;
            "E":     r.code = TERM_E;
            "F":     r.code = TERM_F;
            "G":     r.code = TERM_G;
            "H":     r.code = TERM_H;
            "n":     r.code = TERM_N;
            "s":     r.code = TERM_S;
            "u":     r.code = TERM_U;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] palette(input logic [3:0] idx);
        logic [COLOR_W-1:0] c;
        unique case (idx)
            4'd0:    c = 32'h00000000;
            4'd1:    c = 32'hff800000;
            4'd2:    c = 32'hff008000;
            4'd3:    c = 32'hff808000;
            4'd4:    c = 32'hff0000ff;
            4'd5:    c = 32'hff800080;
            4'd6:    c = 32'hff008080;
            4'd7:    c = 32'hffc0c0c0;
            4'd8:    c = 32'hff808080;
            4'd9:    c = 32'hffff0000;
            4'd10:   c = 32'hff00ff00;
            4'd11:   c = 32'hffffff00;
            4'd12:   c = 32'hff3d97ff;
            4'd13:   c = 32'hffff00ff;
            4'd14:   c = 32'hff00ffff;
            default: c = 32'hffffffff;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/asp_if.sv
interface asp_in_if;
    import asp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] seq_byte;
    logic [COL_W-1:0]  cursor_col;

    modport source (output valid, output seq_byte, output cursor_col, input ready);
    modport sink   (input valid, input seq_byte, input cursor_col, output ready);
endinterface

interface asp_out_if;
    import asp_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic               move_valid;
    logic [COL_W-1:0]   new_cursor_col;
    logic [TERM_W-1:0]  term_code;

    modport source (output valid, output fg_color, output bg_color, output move_valid,
                    output new_cursor_col, output term_code, input ready);
    modport sink   (input valid, input fg_color, input bg_color, input move_valid,
                    input new_cursor_col, input term_code, output ready);
endinterface

FILE: rtl/asp_in_reg.sv
module asp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    asp_in_if.sink            seq_in,
    input  logic              pop,
    output logic              item_valid,
    output asp_pkg::in_item_t item
);
    import asp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    assign seq_in.ready = !valid_reg || pop;
    assign take         = seq_in.valid && seq_in.ready;
    assign valid_next   = take || (valid_reg && !pop);
    assign item_valid   = valid_reg;
    assign item         = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.seq_byte   <= seq_in.seq_byte;
            item_reg.cursor_col <= seq_in.cursor_col;
        end
    end
endmodule

FILE: rtl/asp_core.sv
module asp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  asp_pkg::in_item_t  item,
    input  logic               out_free,
    output logic               pop,
    output logic               res_valid,
    output asp_pkg::res_item_t res
);
    import asp_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } colors_t;

    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] v,
                                                   input logic [BYTE_W-1:0] b);
        logic [NUM_W+3:0] r;
        r = {v, 3'b000} + {3'b000, v, 1'b0} + {(NUM_W-4)'(0), b - CHAR_0};
        return (r > {4'b0000, NUM_SAT}) ? NUM_SAT : r[NUM_W-1:0];
    endfunction

    // one completed token applied to the pending colours
    function automatic colors_t apply_sgr(input colors_t p, input logic [NUM_W-1:0] v,
                                          input logic nonempty);
        colors_t r;
        r = p;
        if (nonempty)
        begin
            if (v == 16'd0)
            begin
                r.fg = WHITE;
                r.bg = BLACK;
            end
            else if (v >= 16'd30 && v <= 16'd37)
                r.fg = palette(4'(v - 16'd30));
            else if (v >= 16'd40 && v <= 16'd47)
                r.bg = palette(4'(v - 16'd40));
            else if (v >= 16'd90 && v <= 16'd97)
                r.fg = palette(4'(v - 16'd90) + 4'd8);
            else if (v >= 16'd100 && v <= 16'd107)
                r.bg = palette(4'(v - 16'd100) + 4'd8);
        end
        return r;
    endfunction

    logic             skip_reg, skip_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [NUM_W-1:0] tok_reg, tok_next;
    logic             tok_nonempty_reg, tok_nonempty_next;
    logic             tok_open_reg, tok_open_next;
    logic [NUM_W-1:0] first_reg, first_next;
    logic             first_open_reg, first_open_next;
    colors_t          pend_reg, pend_next;
    colors_t          cur_reg, cur_next;

    logic             fire;
    logic             is_digit;
    term_hit_t        th;
    colors_t          sgr;
    logic [NUM_W-1:0] move_n;
    logic [COL_W-1:0] col;

    assign fire     = item_valid && out_free;
    assign pop      = fire;
    assign th       = term_lookup(item.seq_byte);
    assign is_digit = (item.seq_byte >= CHAR_0) && (item.seq_byte <= CHAR_9);
    assign sgr      = apply_sgr(pend_reg, tok_reg, tok_nonempty_reg);
    assign col      = item.cursor_col & COL_MASK;
    assign move_n   = (count_reg == '0) ? NUM_W'(1) : first_reg;

    always_comb
    begin
        skip_next         = skip_reg;
        count_next        = count_reg;
        tok_next          = tok_reg;
        tok_nonempty_next = tok_nonempty_reg;
        tok_open_next     = tok_open_reg;
        first_next        = first_reg;
        first_open_next   = first_open_reg;
        pend_next         = pend_reg;
        cur_next          = cur_reg;
        res_valid         = 1'b0;
        res.fg_color       = cur_reg.fg;
        res.bg_color       = cur_reg.bg;
        res.move_valid     = 1'b0;
        res.new_cursor_col = '0;
        res.term_code      = th.code;

        if (fire)
        begin
            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else if (!th.hit)
            begin
                if (count_reg < CNT_W'(SEQ_MAX))
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (first_open_reg)
                    begin
                        if (is_digit)
                            first_next = add_digit(first_reg, item.seq_byte);
                        else
                            first_open_next = 1'b0;
                    end
                    if (item.seq_byte == CHAR_SEMI)
                    begin
                        pend_next         = sgr;
                        tok_next          = '0;
                        tok_nonempty_next = 1'b0;
                        tok_open_next     = 1'b1;
                    end
                    else
                    begin
                        tok_nonempty_next = 1'b1;
                        if (tok_open_reg)
                        begin
                            if (is_digit)
                                tok_next = add_digit(tok_reg, item.seq_byte);
                            else
                                tok_open_next = 1'b0;
                        end
                    end
                end
            end
            else
            begin
                res_valid = 1'b1;
                if (th.code == TERM_M)
                begin
                    cur_next     = sgr;
                    res.fg_color = sgr.fg;
                    res.bg_color = sgr.bg;
                end
                else if (th.code == TERM_D)
                begin
                    if (move_n <= {(NUM_W-COL_W)'(0), col})
                    begin
                        res.move_valid     = 1'b1;
                        res.new_cursor_col = (col - move_n[COL_W-1:0]) & COL_MASK;
                    end
                end
                // start of the next sequence
                skip_next         = 1'b1;
                count_next        = '0;
                tok_next          = '0;
                tok_nonempty_next = 1'b0;
                tok_open_next     = 1'b1;
                first_next        = '0;
                first_open_next   = 1'b1;
                pend_next         = cur_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg         <= 1'b1;
            count_reg        <= '0;
            tok_reg          <= '0;
            tok_nonempty_reg <= 1'b0;
            tok_open_reg     <= 1'b1;
            first_reg        <= '0;
            first_open_reg   <= 1'b1;
            pend_reg.fg      <= WHITE;
            pend_reg.bg      <= BLACK;
            cur_reg.fg       <= WHITE;
            cur_reg.bg       <= BLACK;
        end
        else
        begin
            skip_reg         <= skip_next;
            count_reg        <= count_next;
            tok_reg          <= tok_next;
            tok_nonempty_reg <= tok_nonempty_next;
            tok_open_reg     <= tok_open_next;
            first_reg        <= first_next;
            first_open_reg   <= first_open_next;
            pend_reg         <= pend_next;
            cur_reg          <= cur_next;
        end
    end
endmodule

FILE: rtl/ansi_escape_sgr_parser_top.sv
// csi escape sequence parser
// seq_in carries the bytes that follow an escape byte, one per beat, together
// with the display's current cursor column. the first byte of each sequence
// is dropped; body bytes are collected until a terminator letter arrives.
// res_out gives one beat per terminator: colours after the sequence (updated
// by an 'm' sequence), a cursor move for a 'D' sequence and the terminator
// code. body bytes give no result beat.
// a byte accepted into the input register is parsed combinationally by the core,
// and its result beat is written into the result register.
// throughput: one byte per cycle while res_out does not stall, set by the
// single parse stage between the input register and the result register.
// reset: colours return to white on black and the parser waits for the
// first byte of a new sequence to drop.
// when res_out stalls, the held result waits in the result register; the
// input register still takes one further byte if it is empty, after which
// seq_in.ready stays low until the result beat is taken.
module ansi_escape_sgr_parser_top (
    input  logic      clk,
    input  logic      rst_n,
    asp_in_if.sink    seq_in,
    asp_out_if.source res_out
);
    import asp_pkg::*;

    logic      item_valid;
    in_item_t  item;
    logic      pop;
    logic      res_valid;
    res_item_t res;
    logic      out_free;

    logic      out_valid_reg;
    logic      out_valid_next;
    res_item_t out_reg;

    asp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .seq_in     (seq_in),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    asp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .pop        (pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign out_free       = !out_valid_reg || res_out.ready;
    assign out_valid_next = res_valid || (out_valid_reg && !res_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.fg_color       = out_reg.fg_color;
    assign res_out.bg_color       = out_reg.bg_color;
    assign res_out.move_valid     = out_reg.move_valid;
    assign res_out.new_cursor_col = out_reg.new_cursor_col;
    assign res_out.term_code      = out_reg.term_code;
endmodule

FILE: tb/sv/ansi_escape_sgr_parser_top_tb.sv
`timescale 1ns / 100ps

module ansi_escape_sgr_parser_top_tb;
    import asp_pkg::*;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    class sgr_scoreboard;
        res_item_t   expected_q[$];
        int unsigned errors;
        int unsigned parsed_bytes;
        string       term_letters;

        bit          drop_first;
        int unsigned body_len;
        int unsigned token_val;
        bit          token_seen;
        bit          token_digits;
        int unsigned lead_num;
        bit          lead_open;
        logic [COLOR_W-1:0] pend_fg;
        logic [COLOR_W-1:0] pend_bg;
        logic [COLOR_W-1:0] fg_now;
        logic [COLOR_W-1:0] bg_now;

        function new();
            term_letters = "mJKABCDEFGHnsu";
            errors = 0;
            parsed_bytes = 0;
            fg_now = WHITE;
            bg_now = BLACK;
            start_sequence();
        endfunction

        function void start_sequence();
            drop_first = 1'b1;
            body_len = 0;
            token_val = 0;
            token_seen = 1'b0;
            token_digits = 1'b1;
            lead_num = 0;
            lead_open = 1'b1;
            pend_fg = fg_now;
            pend_bg = bg_now;
        endfunction

        function int unsigned push_digit(int unsigned v, logic [BYTE_W-1:0] b);
            int unsigned r;
            r = v * 10 + int'(b - CHAR_0);
            return (r > NUM_SAT) ? NUM_SAT : r;
        endfunction

        function logic [COLOR_W-1:0] colour_of(int unsigned idx);
            case (idx)
                0:       return 32'h00000000;
                1:       return 32'hff800000;
                2:       return 32'hff008000;
                3:       return 32'hff808000;
                4:       return 32'hff0000ff;
                5:       return 32'hff800080;
                6:       return 32'hff008080;
                7:       return 32'hffc0c0c0;
                8:       return 32'hff808080;
                9:       return 32'hffff0000;
                10:      return 32'hff00ff00;
                11:      return 32'hffffff00;
                12:      return 32'hff3d97ff;
                13:      return 32'hffff00ff;
                14:      return 32'hff00ffff;
                default: return 32'hffffffff;
            endcase
        endfunction

        function void close_token();
            if (token_seen)
            begin
                if (token_val == 0)
                begin
                    pend_fg = WHITE;
                    pend_bg = BLACK;
                end
                else if (token_val >= 30 && token_val <= 37)
                    pend_fg = colour_of(token_val - 30);
                else if (token_val >= 40 && token_val <= 47)
                    pend_bg = colour_of(token_val - 40);
                else if (token_val >= 90 && token_val <= 97)
                    pend_fg = colour_of(token_val - 90 + 8);
                else if (token_val >= 100 && token_val <= 107)
                    pend_bg = colour_of(token_val - 100 + 8);
            end
            token_val = 0;
            token_seen = 1'b0;
            token_digits = 1'b1;
        endfunction

        // called for every accepted input beat
        function void note_byte(logic [BYTE_W-1:0] b, logic [COL_W-1:0] col);
            bit                is_term;
            bit                is_digit;
            logic [TERM_W-1:0] code;
            int unsigned       shift;
            res_item_t         r;
            if (drop_first)
            begin
                drop_first = 1'b0;
                parsed_bytes++;
                return;
            end
            is_term = 1'b0;
            code = TERM_M;
            for (int k = 0; k < term_letters.len(); k++)
            begin
                if (term_letters[k] == b)
                begin
                    is_term = 1'b1;
                    code = TERM_W'(k);
                end
            end
            if (!is_term)
            begin
                // body bytes past the limit are ignored
                if (body_len >= SEQ_MAX)
                    return;
                parsed_bytes++;
                body_len++;
                is_digit = (b >= CHAR_0) && (b <= CHAR_9);
                if (lead_open)
                begin
                    if (is_digit)
                        lead_num = push_digit(lead_num, b);
                    else
                        lead_open = 1'b0;
                end
                if (b == CHAR_SEMI)
                    close_token();
                else
                begin
                    token_seen = 1'b1;
                    if (token_digits)
                    begin
                        if (is_digit)
                            token_val = push_digit(token_val, b);
                        else
                            token_digits = 1'b0;
                    end
                end
                return;
            end
            parsed_bytes++;
            r.move_valid = 1'b0;
            r.new_cursor_col = '0;
            if (code == TERM_M)
            begin
                close_token();
                fg_now = pend_fg;
                bg_now = pend_bg;
            end
            else if (code == TERM_D)
            begin
                shift = (body_len == 0) ? 1 : lead_num;
                if (shift <= col)
                begin
                    r.move_valid = 1'b1;
                    r.new_cursor_col = COL_W'(col - shift);
                end
            end
            r.fg_color = fg_now;
            r.bg_color = bg_now;
            r.term_code = code;
            expected_q.push_back(r);
            start_sequence();
        endfunction

        function void check_result(res_item_t got);
            res_item_t exp_r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result beat fg %h bg %h move %b col %0d term %0d",
                         $time, got.fg_color, got.bg_color, got.move_valid,
                         got.new_cursor_col, got.term_code);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.fg_color !== exp_r.fg_color)
            begin
                $display("%0t: fg_color expected %h got %h", $time, exp_r.fg_color, got.fg_color);
                errors++;
            end
            if (got.bg_color !== exp_r.bg_color)
            begin
                $display("%0t: bg_color expected %h got %h", $time, exp_r.bg_color, got.bg_color);
                errors++;
            end
            if (got.move_valid !== exp_r.move_valid)
            begin
                $display("%0t: move_valid expected %b got %b", $time, exp_r.move_valid,
                         got.move_valid);
                errors++;
            end
            if (got.new_cursor_col !== exp_r.new_cursor_col)
            begin
                $display("%0t: new_cursor_col expected %0d got %0d", $time,
                         exp_r.new_cursor_col, got.new_cursor_col);
                errors++;
            end
            if (got.term_code !== exp_r.term_code)
            begin
                $display("%0t: term_code expected %0d got %0d", $time, exp_r.term_code,
                         got.term_code);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    asp_in_if  seq_in ();
    asp_out_if res_out ();

    ansi_escape_sgr_parser_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .seq_in  (seq_in),
        .res_out (res_out)
    );

    sgr_scoreboard sb;
    int unsigned   idle_pct  = 0;
    int unsigned   stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side: check each accepted beat, then pick the next ready
    initial
    begin
        res_item_t got;
        res_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_out.valid && res_out.ready)
            begin
                got.fg_color = res_out.fg_color;
                got.bg_color = res_out.bg_color;
                got.move_valid = res_out.move_valid;
                got.new_cursor_col = res_out.new_cursor_col;
                got.term_code = res_out.term_code;
                sb.check_result(got);
            end
            res_out.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [COL_W-1:0] col);
        while ($urandom_range(99) < idle_pct)
        begin
            seq_in.valid <= 1'b0;
            @(posedge clk);
        end
        seq_in.valid <= 1'b1;
        seq_in.seq_byte <= b;
        seq_in.cursor_col <= col;
        @(posedge clk);
        while (!seq_in.ready)
            @(posedge clk);
        sb.note_byte(b, col);
    endtask

    task automatic send_seq(input byte_q_t bytes, input logic [COL_W-1:0] last_col);
        foreach (bytes[i])
        begin
            if (i == bytes.size() - 1)
                send_byte(bytes[i], last_col);
            else
                send_byte(bytes[i], COL_W'($urandom_range(4095)));
        end
    endtask

    function automatic byte_q_t to_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic string colour_token();
        case ($urandom_range(8))
            0:       return "0";
            1:       return $sformatf("%0d", 30 + $urandom_range(7));
            2:       return $sformatf("%0d", 40 + $urandom_range(7));
            3:       return $sformatf("%0d", 90 + $urandom_range(7));
            4:       return $sformatf("%0d", 100 + $urandom_range(7));
            5:       return $sformatf("%0d", $urandom_range(200));
            6:       return $sformatf("%0d", $urandom_range(99999));
            // no leading digits, or digits cut short by junk
            7:       return $sformatf("-%0d", $urandom_range(107));
            default: return ($urandom_range(1) == 0) ? "" : $sformatf("%0dx1", $urandom_range(47));
        endcase
    endfunction

    function automatic byte_q_t random_sequence(output logic [COL_W-1:0] last_col);
        byte_q_t q;
        string   body;
        string   terms;
        int      kind;
        int      n;
        terms = "mJKABCDEFGHnsu";
        body = "";
        if ($urandom_range(9) == 0)
            q.push_back(BYTE_W'($urandom_range(255)));
        else
            q.push_back("[");
        last_col = COL_W'($urandom_range(4095));
        kind = $urandom_range(9);
        if (kind < 5)
        begin
            n = $urandom_range(5);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    body = {body, ";"};
                body = {body, colour_token()};
            end
            if ($urandom_range(7) == 0)
                body = {body, ";;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;0"};
            q = {q, to_bytes({body, "m"})};
        end
        else if (kind < 8)
        begin
            if ($urandom_range(3) != 0)
            begin
                if ($urandom_range(3) == 0)
                    body = $sformatf("%0d", $urandom_range(99999));
                else
                    body = $sformatf("%0d", $urandom_range(20));
            end
            if ($urandom_range(3) == 0)
                body = {body, ";", colour_token()};
            if ($urandom_range(1) == 0)
                last_col = COL_W'($urandom_range(20));
            q = {q, to_bytes({body, "D"})};
        end
        else
        begin
            // raw noise, sometimes past the length limit
            n = ($urandom_range(4) == 0) ? $urandom_range(32, 45) : $urandom_range(8);
            repeat (n)
                q.push_back(BYTE_W'($urandom_range(255)));
            q.push_back(terms[$urandom_range(13)]);
        end
        return q;
    endfunction

    initial
    begin
        byte_q_t          q;
        logic [COL_W-1:0] col;
        int unsigned      target;
        sb = new();
        seq_in.valid = 1'b0;
        seq_in.seq_byte = '0;
        seq_in.cursor_col = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // terminator as first byte is dropped; empty 'D' at column zero cannot move
        send_seq(to_bytes("mD"), 12'd0);
        send_seq(to_bytes("[D"), 12'd4095);
        q = to_bytes("[0D");
        q[0] = 8'hff;
        send_seq(q, 12'd7);
        q = to_bytes("[?;97;;107m");
        q[1] = 8'h00;
        send_seq(q, 12'd0);
        send_seq(to_bytes("[70000D"), 12'd4095);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 79;
                end
                default:
                begin
                    idle_pct = 20;
                    stall_pct = 20;
                end
            endcase
            target = sb.parsed_bytes + 125;
            while (sb.parsed_bytes < target)
            begin
                q = random_sequence(col);
                send_seq(q, col);
            end
            // hold off until every result beat is back
            seq_in.valid <= 1'b0;
            do
                @(posedge clk);
            while (sb.expected_q.size() != 0);
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
